// ===== hw/rtl/sclex_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sclex_pkg
// Shared types, codes and character constants for the command line lexer.
// ----------------------------------------------------------------------------
package sclex_pkg;

    // queue depth between classifier and emitter
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        MODE_START    = 4'd0,
        MODE_BLANK    = 4'd1,
        MODE_LETTER   = 4'd2,
        MODE_REDIR    = 4'd3,
        MODE_SQ       = 4'd4,
        MODE_DQ       = 4'd5,
        MODE_SQ_CLOSE = 4'd6,
        MODE_DQ_CLOSE = 4'd7,
        MODE_SQ_ESC   = 4'd8,
        MODE_DQ_ESC   = 4'd9,
        MODE_DROP     = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_LINE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_REDIR_FIRST = 3'd0,
        ERR_BAD_CHAR    = 3'd1,
        ERR_REDIR_END   = 3'd2,
        ERR_AFTER_REDIR = 3'd3,
        ERR_TOO_MANY_GT = 3'd4,
        ERR_GT_GAP      = 3'd5,
        ERR_UNCLOSED    = 3'd6,
        ERR_NONE        = 3'd7
    } err_t;

    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DEL    = 8'd127;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // one result word
    typedef struct packed {
        logic [2:0] err;
        logic       spec;
        logic [7:0] chr;
        kind_t      kind;
    } result_t;

    // what one input byte produces: one or two result words
    typedef struct packed {
        logic    two;
        result_t r1;
        result_t r0;
    } entry_t;

    function automatic result_t res_char(input logic [7:0] c);
        result_t r;
        r.kind = KIND_CHAR;
        r.chr  = c;
        r.spec = 1'b0;
        r.err  = 3'd0;
        return r;
    endfunction

    function automatic result_t res_end(input logic spec);
        result_t r;
        r.kind = KIND_END;
        r.chr  = 8'd0;
        r.spec = spec;
        r.err  = 3'd0;
        return r;
    endfunction

    function automatic result_t res_line();
        result_t r;
        r.kind = KIND_LINE;
        r.chr  = 8'd0;
        r.spec = 1'b0;
        r.err  = 3'd0;
        return r;
    endfunction

    function automatic result_t res_err(input err_t code);
        result_t r;
        r.kind = KIND_ERR;
        r.chr  = 8'd0;
        r.spec = 1'b0;
        r.err  = code;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/shell_command_line_lexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shell_command_line_lexer
// Byte-at-a-time command line lexer: token characters, token ends, line
// done marks and error codes, one result word per handshake.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                | tuser     | tlast
//  s_axis   | in  | [7:0] byte                           | -         | -
//  m_axis   | out | [7:0] char, [8] special, [11:9] error | [1:0] kind | last word of byte
//
// A byte is taken every cycle while the entry queue has room; the byte is
// classified and its words, if any (one or two), are queued in that same cycle.
// The emitter drains one word per cycle while m_tready is high; a byte giving
// two words sends both in turn, and the queue absorbs short bursts of them.
// Reset (rst_n low, asynchronous) puts the lexer at start of line with an
// empty queue and no word on the output. Output stalls back up through the
// queue to s_tready; input gaps leave the output side running.
// ----------------------------------------------------------------------------
module shell_command_line_lexer
#(
    parameter int QUEUE_DEPTH = sclex_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_char, [8] token_special,
                                        // [11:9] error_code, [15:12] zero
    output logic [1:0]       m_tuser,   // [1:0] out_kind
    output logic             m_tlast    // last_of_run
);
    import sclex_pkg::*;

    logic    push, q_full, q_valid, pop;
    entry_t  push_entry, q_head;
    result_t res;

    sclex_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    sclex_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    sclex_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, res.err, res.spec, res.chr};
    assign m_tuser = res.kind;

endmodule
`default_nettype wire

// ===== hw/rtl/sclex_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sclex_front
// Classifies each incoming byte against the lexer mode and queues the
// result words it causes as one entry.
// ----------------------------------------------------------------------------
module sclex_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             q_full,
    output logic                  push,
    output sclex_pkg::entry_t     push_entry
);
    import sclex_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [1:0] rcnt_reg, rcnt_next;
    logic [7:0] prev_reg;

    logic c_nl, c_dq, c_sq, c_bs, c_ltp, c_gt, c_redir, c_space, c_print;
    logic esc_known;
    logic [7:0] esc_val;
    logic emit, two;
    result_t r0, r1;
    logic accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // byte classes
    assign c_nl    = (in_byte == CH_NL);
    assign c_dq    = (in_byte == CH_DQUOTE);
    assign c_sq    = (in_byte == CH_SQUOTE);
    assign c_bs    = (in_byte == CH_BSLASH);
    assign c_ltp   = (in_byte == CH_LT) || (in_byte == CH_PIPE);
    assign c_gt    = (in_byte == CH_GT);
    assign c_redir = c_ltp || c_gt;
    assign c_space = (in_byte == CH_SPACE);
    assign c_print = (in_byte >= CH_SPACE) && (in_byte <= CH_DEL);

    always_comb
    begin
        esc_known = 1'b1;
        esc_val   = 8'd0;
        case (in_byte)
            CH_N:    esc_val = 8'd10;
            CH_B:    esc_val = 8'd8;
            CH_R:    esc_val = 8'd13;
            CH_T:    esc_val = 8'd9;
            CH_V:    esc_val = 8'd11;
            CH_ZERO: esc_val = 8'd0;
            default: esc_known = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        rcnt_next = rcnt_reg;
        unique case (mode_reg)
            MODE_START, MODE_BLANK:
            begin
                if (c_nl)                        mode_next = MODE_START;
                else if (c_dq)                   mode_next = MODE_DQ;
                else if (c_sq)                   mode_next = MODE_SQ;
                else if (c_redir)
                begin
                    if (mode_reg == MODE_START)  mode_next = MODE_DROP;
                    else
                    begin
                        mode_next = MODE_REDIR;
                        rcnt_next = {1'b0, c_gt};
                    end
                end
                else if (c_space)                mode_next = mode_reg;
                else if (c_print)                mode_next = MODE_LETTER;
                else                             mode_next = MODE_DROP;
            end
            MODE_LETTER, MODE_SQ_CLOSE, MODE_DQ_CLOSE:
            begin
                if (c_nl)                        mode_next = MODE_START;
                else if (c_dq)                   mode_next = MODE_DQ;
                else if (c_sq)                   mode_next = MODE_SQ;
                else if (c_redir)
                begin
                    mode_next = MODE_REDIR;
                    rcnt_next = {1'b0, c_gt};
                end
                else if (c_space)                mode_next = MODE_BLANK;
                else if (c_print)                mode_next = MODE_LETTER;
                else                             mode_next = MODE_DROP;
            end
            MODE_REDIR:
            begin
                if (c_dq)                        mode_next = MODE_DQ;
                else if (c_sq)                   mode_next = MODE_SQ;
                else if (c_nl)                   mode_next = MODE_START;
                else if (c_ltp)                  mode_next = MODE_DROP;
                else if (c_gt)
                begin
                    if (prev_reg != CH_GT || rcnt_reg >= 2'd2)
                        mode_next = MODE_DROP;
                    else
                        rcnt_next = rcnt_reg + 2'd1;
                end
                else if (c_space)                mode_next = MODE_REDIR;
                else if (c_print)                mode_next = MODE_LETTER;
                else                             mode_next = MODE_DROP;
            end
            MODE_SQ:
            begin
                if (c_sq)                        mode_next = MODE_SQ_CLOSE;
                else if (c_nl)                   mode_next = MODE_START;
                else if (c_bs)                   mode_next = MODE_SQ_ESC;
            end
            MODE_DQ:
            begin
                if (c_dq)                        mode_next = MODE_DQ_CLOSE;
                else if (c_nl)                   mode_next = MODE_START;
                else if (c_bs)                   mode_next = MODE_DQ_ESC;
            end
            MODE_SQ_ESC:                         mode_next = c_nl ? MODE_START : MODE_SQ;
            MODE_DQ_ESC:                         mode_next = c_nl ? MODE_START : MODE_DQ;
            default:                             mode_next = c_nl ? MODE_START : MODE_DROP;
        endcase
    end

    // result words
    always_comb
    begin
        emit = 1'b0;
        two  = 1'b0;
        r0   = res_char(in_byte);
        r1   = res_char(in_byte);
        unique case (mode_reg)
            MODE_START, MODE_BLANK:
            begin
                if (c_nl)
                begin
                    emit = 1'b1;
                    r0   = res_line();
                end
                else if (c_dq || c_sq || c_space)
                    emit = 1'b0;
                else if (c_redir)
                begin
                    emit = 1'b1;
                    if (mode_reg == MODE_START) r0 = res_err(ERR_REDIR_FIRST);
                end
                else if (c_print)
                    emit = 1'b1;
                else
                begin
                    emit = 1'b1;
                    r0   = res_err(ERR_BAD_CHAR);
                end
            end
            MODE_LETTER, MODE_SQ_CLOSE, MODE_DQ_CLOSE:
            begin
                if (c_nl)
                begin
                    emit = 1'b1;
                    two  = 1'b1;
                    r0   = res_end(1'b0);
                    r1   = res_line();
                end
                else if (c_dq || c_sq)
                    emit = 1'b0;
                else if (c_redir)
                begin
                    emit = 1'b1;
                    two  = 1'b1;
                    r0   = res_end(1'b0);
                end
                else if (c_space)
                begin
                    emit = 1'b1;
                    r0   = res_end(1'b0);
                end
                else if (c_print)
                    emit = 1'b1;
                else
                begin
                    emit = 1'b1;
                    r0   = res_err(ERR_BAD_CHAR);
                end
            end
            MODE_REDIR:
            begin
                emit = 1'b1;
                if (c_dq || c_sq)        r0 = res_end(1'b1);
                else if (c_nl)           r0 = res_err(ERR_REDIR_END);
                else if (c_ltp)          r0 = res_err(ERR_AFTER_REDIR);
                else if (c_gt)
                begin
                    if (prev_reg != CH_GT)       r0 = res_err(ERR_GT_GAP);
                    else if (rcnt_reg >= 2'd2)   r0 = res_err(ERR_TOO_MANY_GT);
                end
                else if (c_space)        emit = 1'b0;
                else if (c_print)
                begin
                    two = 1'b1;
                    r0  = res_end(1'b1);
                end
                else                     r0 = res_err(ERR_BAD_CHAR);
            end
            MODE_SQ, MODE_DQ:
            begin
                if ((mode_reg == MODE_SQ && c_sq) || (mode_reg == MODE_DQ && c_dq) || c_bs)
                    emit = 1'b0;
                else if (c_nl)
                begin
                    emit = 1'b1;
                    r0   = res_err(ERR_UNCLOSED);
                end
                else
                    emit = 1'b1;
            end
            MODE_SQ_ESC, MODE_DQ_ESC:
            begin
                emit = 1'b1;
                if (c_nl)           r0 = res_err(ERR_UNCLOSED);
                else if (esc_known) r0 = res_char(esc_val);
                else
                begin
                    // unknown escape keeps the backslash
                    two = 1'b1;
                    r0  = res_char(CH_BSLASH);
                end
            end
            default:
                emit = 1'b0;
        endcase
    end

    assign push          = accept && emit;
    assign push_entry.two = two;
    assign push_entry.r0  = r0;
    assign push_entry.r1  = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_START;
            rcnt_reg <= 2'd0;
            prev_reg <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            rcnt_reg <= rcnt_next;
            prev_reg <= in_byte;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sclex_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sclex_queue
// Small FIFO of result entries between classifier and emitter.
// ----------------------------------------------------------------------------
module sclex_queue
#(
    parameter int DEPTH = sclex_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sclex_pkg::entry_t push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output sclex_pkg::entry_t      head
);
    import sclex_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    entry_t          mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wp_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wp_reg <= (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
            if (do_pop)  rp_reg <= (rp_reg == LAST) ? '0 : rp_reg + 1'b1;
            if (do_push && !do_pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sclex_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sclex_back
// Unpacks queued entries into single result words behind an output register.
// ----------------------------------------------------------------------------
module sclex_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire sclex_pkg::entry_t q_head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sclex_pkg::result_t     out_res,
    output logic                   out_last
);
    import sclex_pkg::*;

    logic    valid_reg;
    logic    phase_reg, phase_next;
    result_t res_reg, res_next;
    logic    last_reg, last_next;
    logic    load;

    assign load = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        phase_next = phase_reg;
        pop        = 1'b0;
        res_next   = q_head.r0;
        last_next  = !q_head.two;
        if (load)
        begin
            if (phase_reg)
            begin
                res_next   = q_head.r1;
                last_next  = 1'b1;
                pop        = 1'b1;
                phase_next = 1'b0;
            end
            else if (q_head.two)
                phase_next = 1'b1;
            else
                pop = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)           valid_reg <= 1'b1;
            else if (out_ready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res_next;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire
